// File: design/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  localparam int WAIT_BITS_DEF = 16;
  localparam int CFG_W         = 16;
  localparam int DATA_BITS     = 8;
  localparam int WRITE_EDGES   = 18;
  localparam int PHASE_W       = 5;
  localparam int OP_W          = 3;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_W-1:0] PRE_WAIT_RST  = CFG_W'(10);
  localparam logic [CFG_W-1:0] POST_WAIT_RST = CFG_W'(10);

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_START   = 3'd1,
    OP_RESTART = 3'd2,
    OP_STOP    = 3'd3,
    OP_WRITE   = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_WAIT  = 2'd0,
    REG_POST_WAIT = 2'd1,
    REG_STRETCH   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    SUB_PRE     = 2'd0,
    SUB_STRETCH = 2'd1,
    SUB_POST    = 2'd2
  } edge_sub_e;

  // one SCL edge of a command
  typedef struct packed {
    logic sda_en;   // set SDA before the edge
    logic sda_val;
    logic lvl;      // SCL level after the edge
    logic smp;      // sample SDA when the edge closes
    logic last;     // last edge of the command
  } edge_t;

  function automatic edge_t edge_info(logic [OP_W-1:0] op, logic [PHASE_W-1:0] idx,
                                      logic [DATA_BITS-1:0] shift, logic nack);
    edge_t e;
    e = '0;
    case (op)
      OP_START: begin
        e.sda_en = 1'b1; e.sda_val = 1'b0; e.last = 1'b1;
      end
      OP_RESTART: begin
        e.sda_en = 1'b1;
        if (idx == '0) begin
          e.sda_val = 1'b1; e.lvl = 1'b1;
        end else begin
          e.sda_val = 1'b0; e.last = 1'b1;
        end
      end
      OP_STOP: begin
        e.sda_en = 1'b1; e.sda_val = 1'b0; e.lvl = 1'b1; e.last = 1'b1;
      end
      OP_WRITE: begin
        if (idx < PHASE_W'(2 * DATA_BITS)) begin
          if (!idx[0]) begin
            // MSB first: bit 7 - idx/2
            e.sda_en  = 1'b1;
            e.sda_val = shift[~idx[3:1]];
            e.lvl     = 1'b1;
          end
        end else if (idx == PHASE_W'(WRITE_EDGES - 2)) begin
          e.sda_en = 1'b1; e.sda_val = 1'b1; e.lvl = 1'b1; e.smp = 1'b1;
        end else begin
          e.last = 1'b1;
        end
      end
      default: begin
        if (idx == '0) begin
          e.sda_en = 1'b1; e.sda_val = 1'b1;
        end else if (idx <= PHASE_W'(2 * DATA_BITS)) begin
          if (idx[0]) begin
            e.lvl = 1'b1; e.smp = 1'b1;
          end
        end else if (idx == PHASE_W'(2 * DATA_BITS + 1)) begin
          e.sda_en = 1'b1; e.sda_val = nack; e.lvl = 1'b1;
        end else begin
          e.last = 1'b1;
        end
      end
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// File: design/i2c_master_byte_engine_unit.sv
// I2C master bit engine, one timer tick per input transfer.
// Slave side (s_axis_*): one transfer per tick. tuser carries the command
// (0 tick, 1 start, 2 repeated start, 3 stop, 4 write byte, 5 read byte);
// tdata carries tx_byte, nack_last and the sampled SDA/SCL line levels.
// Master side (m_axis_*): exactly one result transfer per input transfer with
// the SCL/SDA drive levels, busy, done, the last write's ACK and last read byte.
// Config channel (cfg_*), always ready: register index 0 pre-edge wait, 1 post-
// edge wait, 2 stretch enable; user writes only while engine is idle, unchecked.
// Latency: the result of a tick is valid the cycle after its transfer.
// Throughput: one tick per cycle; the state update and result encoding are a
// single combinational pass into the state and result registers.
// A stalled master side holds the result register and drops s_axis_tready
// only while that register is full and not being taken.
// Reset: lines released high, no command in progress, waits back to 10 ticks,
// stretch off, held ACK and read byte cleared.
`default_nettype none
module i2c_master_byte_engine_unit
  import i2cm_pkg::*;
#(
  parameter int WAIT_BITS = WAIT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [7:0] tx_byte, [8] nack_last, [9] sda_in, [10] scl_in, [15:11] zero
  input  wire logic [15:0]          s_axis_tdata,
  // [2:0] op
  input  wire logic [OP_W-1:0]      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] acked,
  // [12:5] rx_byte, [15:13] zero
  output logic [15:0]               m_axis_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int CMP_W = (WAIT_BITS > CFG_W) ? WAIT_BITS : CFG_W;
  localparam logic [CMP_W-1:0] WAIT_MAX = CMP_W'({WAIT_BITS{1'b1}});

  // config
  logic [CFG_W-1:0] pre_wait_q, post_wait_q;
  logic             stretch_q;

  // engine state
  logic [OP_W-1:0]      cmd_op_q, cmd_op_d;
  logic                 cmd_nack_q, cmd_nack_d;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [WAIT_BITS-1:0] wait_q, wait_d;
  edge_sub_e            sub_q, sub_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic                 ack_q, ack_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic [DATA_BITS-1:0] hold_q, hold_d;
  logic                 done_d;

  // result register
  logic        out_valid_q;
  logic [15:0] out_data_q, out_data_d;

  logic [OP_W-1:0]      in_op;
  logic [DATA_BITS-1:0] in_tx;
  logic                 in_nack, in_sda, in_scl;
  logic                 accept;
  logic [CMP_W-1:0]     pre_lim, post_lim, wait_ext;
  edge_t                ed;

  assign in_op   = s_axis_tuser;
  assign in_tx   = s_axis_tdata[7:0];
  assign in_nack = s_axis_tdata[8];
  assign in_sda  = s_axis_tdata[9];
  assign in_scl  = s_axis_tdata[10];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // waits longer than the counter saturate at its largest value
  assign pre_lim  = (CMP_W'(pre_wait_q) > WAIT_MAX) ? WAIT_MAX : CMP_W'(pre_wait_q);
  assign post_lim = (CMP_W'(post_wait_q) > WAIT_MAX) ? WAIT_MAX : CMP_W'(post_wait_q);
  assign wait_ext = CMP_W'(wait_q);

  assign ed = edge_info(cmd_op_q, phase_q, shift_q, cmd_nack_q);

  always_comb begin
    logic post_chk;
    cmd_op_d   = cmd_op_q;
    cmd_nack_d = cmd_nack_q;
    phase_d    = phase_q;
    wait_d     = wait_q;
    sub_d      = sub_q;
    shift_d    = shift_q;
    ack_d      = ack_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    hold_d     = hold_q;
    done_d     = 1'b0;
    post_chk   = 1'b0;

    if (cmd_op_q == OP_TICK) begin
      if (in_op >= OP_START && in_op <= OP_READ) begin
        cmd_op_d   = in_op;
        cmd_nack_d = in_nack;
        phase_d    = '0;
        wait_d     = '0;
        sub_d      = SUB_PRE;
        shift_d    = (in_op == OP_WRITE) ? in_tx : '0;
      end
    end else begin
      case (sub_q)
        SUB_PRE: begin
          if (ed.sda_en) sda_d = ed.sda_val;
          if (wait_ext < pre_lim) begin
            wait_d = wait_q + 1'b1;
          end else begin
            scl_d  = ed.lvl;
            wait_d = '0;
            sub_d  = (stretch_q && ed.lvl) ? SUB_STRETCH : SUB_POST;
          end
        end
        SUB_STRETCH: begin
          if (in_scl) begin
            sub_d    = SUB_POST;
            post_chk = 1'b1;
          end
        end
        default: post_chk = 1'b1;
      endcase

      if (post_chk) begin
        if (wait_ext < post_lim) begin
          wait_d = wait_q + 1'b1;
        end else begin
          if (ed.smp) begin
            if (cmd_op_q == OP_WRITE) ack_d = !in_sda;
            else shift_d = {shift_q[DATA_BITS-2:0], in_sda};
          end
          wait_d = '0;
          sub_d  = SUB_PRE;
          if (ed.last) begin
            if (cmd_op_q == OP_STOP || cmd_op_q == OP_READ) sda_d = 1'b1;
            if (cmd_op_q == OP_READ) hold_d = shift_q;
            cmd_op_d   = OP_TICK;
            cmd_nack_d = 1'b0;
            phase_d    = '0;
            done_d     = 1'b1;
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
    end

    out_data_d = {3'b000, hold_d, ack_d, done_d, (cmd_op_d != OP_TICK), sda_d, scl_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_wait_q  <= PRE_WAIT_RST;
      post_wait_q <= POST_WAIT_RST;
      stretch_q   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRE_WAIT:  pre_wait_q  <= cfg_data;
        REG_POST_WAIT: post_wait_q <= cfg_data;
        REG_STRETCH:   stretch_q   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_op_q    <= OP_TICK;
      cmd_nack_q  <= 1'b0;
      phase_q     <= '0;
      wait_q      <= '0;
      sub_q       <= SUB_PRE;
      shift_q     <= '0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cmd_op_q    <= cmd_op_d;
        cmd_nack_q  <= cmd_nack_d;
        phase_q     <= phase_d;
        wait_q      <= wait_d;
        sub_q       <= sub_d;
        shift_q     <= shift_d;
        ack_q       <= ack_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        hold_q      <= hold_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_data_q <= out_data_d;
  end

endmodule
`default_nettype wire

// File: design/i2cm_checker.sv
`default_nettype none
module i2cm_checker
  import i2cm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // a result that is not taken stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // each input transfer shows up as a result the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("result missing after input transfer");

  // an empty result register never backpressures the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a finishing command is no longer busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done while still busy");

  // an empty result register stays empty until an input transfer
  a_no_result_without_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("result without input transfer");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_i2cm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
